>>> sv/aoi_pkg.sv
// ----------------------------------------------------------------------------
// aoi_pkg: shared types and constants of the area-of-interest filter
// Field widths, command and status codes, table geometry and the words that
// move between the front queue, the back sequencer and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aoi_pkg;

   localparam int MAX_ENTITIES = 64;
   localparam int COORD_BITS   = 20;

   localparam int IDX_W     = $clog2(MAX_ENTITIES);
   localparam int CNT_W     = $clog2(MAX_ENTITIES + 1);
   localparam int ID_W      = 32;
   localparam int FRAME_W   = 32;
   localparam int ACT_W     = 3;
   localparam int STAT_W    = 3;
   localparam int PRIO_W    = 2;
   localparam int RAD_W     = 19;
   localparam int FRAC_W    = 10;
   localparam int IV_W      = 8;
   localparam int CSR_W     = 19;
   localparam int CSR_IDX_W = 3;

   localparam int DIFF_W  = COORD_BITS;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int DIST_W  = SQ_W + 2;
   localparam int SDIST_W = DIST_W + 16;
   localparam int RSQ_W   = 2 * RAD_W;
   localparam int FSQ_W   = 2 * FRAC_W;
   localparam int PROD_W  = FSQ_W + RAD_W;
   localparam int BND_W   = FSQ_W + RSQ_W;
   localparam int CMP_W   = (SDIST_W > BND_W) ? SDIST_W : BND_W;
   localparam int MOD_CNT_W = $clog2(FRAME_W + 1);

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd0;
   localparam logic [ACT_W-1:0] ACT_MOVE     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_HIT     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NONE    = 3'd4;

   localparam logic [PRIO_W-1:0] PRIO_NEAR = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_FAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CFG_RADIUS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_NEAR_FR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_FAR_FR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_NEAR_IV  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_MID_IV   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_FAR_IV   = 3'd5;

   localparam logic [RAD_W-1:0]  RADIUS_RST  = 19'd1600;
   localparam logic [FRAC_W-1:0] NEAR_FR_RST = 10'd77;
   localparam logic [FRAC_W-1:0] FAR_FR_RST  = 10'd179;
   localparam logic [IV_W-1:0]   NEAR_IV_RST = 8'd1;
   localparam logic [IV_W-1:0]   MID_IV_RST  = 8'd2;
   localparam logic [IV_W-1:0]   FAR_IV_RST  = 8'd4;

   typedef struct packed {
      logic [ACT_W-1:0]             action;
      logic [ID_W-1:0]              entity_id;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic [FRAME_W-1:0]           frame_number;
   } aoi_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   found_id;
      logic [PRIO_W-1:0] priority_res;
      logic              update_now;
      logic              last;
   } aoi_rsp_type;

   typedef struct packed {
      aoi_req_type req;
      logic        lookup;
   } aoi_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]              key;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } aoi_entry_type;

   typedef struct packed {
      logic [RSQ_W-1:0] r_sq;
      logic [BND_W-1:0] near_b;
      logic [BND_W-1:0] far_b;
      logic [IV_W-1:0]  near_iv;
      logic [IV_W-1:0]  mid_iv;
      logic [IV_W-1:0]  far_iv;
   } aoi_thr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DECIDE,
      ST_QSCAN,
      ST_FIN
   } aoi_state_type;

endpackage

>>> sv/aoi_front.sv
// ----------------------------------------------------------------------------
// aoi_front: command intake and queue
// Takes command words, tags those that need a table lookup and holds them in
// a two-entry queue for the back sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aoi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  aoi_pkg::aoi_req_type req_data,
   output logic                 busy,
   input  logic                 pop,
   output logic                 cmd_valid,
   output aoi_pkg::aoi_cmd_type cmd
);

   aoi_pkg::aoi_cmd_type             q_ff [aoi_pkg::QDEPTH];
   logic [aoi_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [aoi_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [aoi_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                             push;
   logic                             do_pop;
   aoi_pkg::aoi_cmd_type             new_cmd;

   assign busy      = (cnt_ff == aoi_pkg::QCNT_W'(aoi_pkg::QDEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign do_pop    = pop && cmd_valid;

   always_comb begin
      new_cmd.req    = req_data;
      new_cmd.lookup = req_data.action inside {aoi_pkg::ACT_REGISTER, aoi_pkg::ACT_MOVE,
                                               aoi_pkg::ACT_REMOVE, aoi_pkg::ACT_QUERY};
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == aoi_pkg::QPTR_W'(aoi_pkg::QDEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == aoi_pkg::QPTR_W'(aoi_pkg::QDEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> sv/aoi_mod.sv
// ----------------------------------------------------------------------------
// aoi_mod: serial frame remainder
// Restoring remainder of the frame number by an update interval, one bit per
// cycle; flags a zero remainder (a zero interval always flags).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aoi_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aoi_pkg::FRAME_W-1:0] dividend,
   input  logic [aoi_pkg::IV_W-1:0]    divisor,
   output logic                        zero_hit
);

   logic [aoi_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [aoi_pkg::FRAME_W-1:0]   quo_ff, quo_in;
   logic [aoi_pkg::IV_W-1:0]      rem_ff, rem_in;
   logic [aoi_pkg::IV_W:0]        trial;
   logic [aoi_pkg::IV_W:0]        diff;

   assign trial    = {rem_ff, quo_ff[aoi_pkg::FRAME_W-1]};
   assign diff     = trial - {1'b0, divisor};
   assign zero_hit = (divisor == '0) || (rem_ff == '0);

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = aoi_pkg::MOD_CNT_W'(aoi_pkg::FRAME_W);
         quo_in = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[aoi_pkg::FRAME_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? diff[aoi_pkg::IV_W-1:0] :
                  trial[aoi_pkg::IV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

>>> sv/aoi_back.sv
// ----------------------------------------------------------------------------
// aoi_back: table sequencer
// Holds the entity table, scans it to resolve ids, applies table updates and
// runs the query scan through a distance pipeline, one slot per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aoi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  aoi_pkg::aoi_cmd_type cmd,
   output logic                 pop,
   input  aoi_pkg::aoi_thr_type thr,
   output logic                 rsp_strobe,
   output aoi_pkg::aoi_rsp_type rsp_data
);

   function automatic logic [aoi_pkg::DIFF_W-1:0] abs_diff(
      input logic signed [aoi_pkg::COORD_BITS-1:0] a,
      input logic signed [aoi_pkg::COORD_BITS-1:0] b
   );
      logic signed [aoi_pkg::COORD_BITS:0] d;
      logic signed [aoi_pkg::COORD_BITS:0] m;
      d = {a[aoi_pkg::COORD_BITS-1], a} - {b[aoi_pkg::COORD_BITS-1], b};
      m = d[aoi_pkg::COORD_BITS] ? -d : d;
      return m[aoi_pkg::DIFF_W-1:0];
   endfunction

   aoi_pkg::aoi_state_type state_ff, state_in;

   aoi_pkg::aoi_entry_type        mem [aoi_pkg::MAX_ENTITIES];
   logic [aoi_pkg::MAX_ENTITIES-1:0] valid_ff;

   aoi_pkg::aoi_req_type          cmd_ff;
   logic [aoi_pkg::CNT_W-1:0]     scan_cnt_ff;

   aoi_pkg::aoi_entry_type        rd_ff;
   logic                          rd_vld_ff;
   logic                          rd_end_ff;
   logic [aoi_pkg::IDX_W-1:0]     rd_idx_ff;

   logic                          found_ff;
   logic [aoi_pkg::IDX_W-1:0]     found_idx_ff;
   logic                          free_ff;
   logic [aoi_pkg::IDX_W-1:0]     free_idx_ff;
   logic signed [aoi_pkg::COORD_BITS-1:0] obs_x_ff, obs_y_ff, obs_z_ff;

   logic [aoi_pkg::DIFF_W-1:0]    dx_ff, dy_ff, dz_ff;
   logic [aoi_pkg::ID_W-1:0]      p2_key_ff;
   logic                          p2_vld_ff, p2_end_ff;
   logic [aoi_pkg::SQ_W-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [aoi_pkg::ID_W-1:0]      p3_key_ff;
   logic                          p3_vld_ff, p3_end_ff;
   logic [aoi_pkg::DIST_W-1:0]    dist_ff;
   logic [aoi_pkg::ID_W-1:0]      p4_key_ff;
   logic                          p4_vld_ff, p4_end_ff;

   logic                          pend_vld_ff;
   aoi_pkg::aoi_rsp_type          pend_ff;
   logic                          rsp_strobe_ff;
   aoi_pkg::aoi_rsp_type          rsp_ff;

   logic                          issue;
   logic                          mem_we;
   logic [aoi_pkg::IDX_W-1:0]     wr_idx;
   aoi_pkg::aoi_entry_type        wr_entry;
   logic                          set_valid, clr_valid, clr_all;
   logic                          emit;
   aoi_pkg::aoi_rsp_type          emit_rsp;
   logic                          pend_load, pend_clr;
   logic                          look_vld, match, free_hit;
   logic                          hit;
   aoi_pkg::aoi_rsp_type          hit_rsp;
   logic [aoi_pkg::CMP_W-1:0]     d_ext, ds_ext;
   logic                          near_lt, far_lt;
   logic                          zn, zm, zf;

   aoi_mod u_mod_near (
      .clock(clock), .reset(reset), .start(pop),
      .dividend(cmd.req.frame_number), .divisor(thr.near_iv), .zero_hit(zn)
   );
   aoi_mod u_mod_mid (
      .clock(clock), .reset(reset), .start(pop),
      .dividend(cmd.req.frame_number), .divisor(thr.mid_iv), .zero_hit(zm)
   );
   aoi_mod u_mod_far (
      .clock(clock), .reset(reset), .start(pop),
      .dividend(cmd.req.frame_number), .divisor(thr.far_iv), .zero_hit(zf)
   );

   assign look_vld = (state_ff == aoi_pkg::ST_LOOK) && rd_vld_ff;
   assign match    = look_vld && valid_ff[rd_idx_ff] && !found_ff &&
                     (rd_ff.key == cmd_ff.entity_id);
   assign free_hit = look_vld && !valid_ff[rd_idx_ff] && !free_ff;

   always_comb begin
      d_ext   = aoi_pkg::CMP_W'(dist_ff);
      ds_ext  = aoi_pkg::CMP_W'(dist_ff) << 16;
      hit     = p4_vld_ff && (d_ext <= aoi_pkg::CMP_W'(thr.r_sq));
      near_lt = ds_ext < aoi_pkg::CMP_W'(thr.near_b);
      far_lt  = ds_ext < aoi_pkg::CMP_W'(thr.far_b);
      hit_rsp.status   = aoi_pkg::STAT_HIT;
      hit_rsp.found_id = p4_key_ff;
      hit_rsp.last     = 1'b0;
      if (near_lt) begin
         hit_rsp.priority_res = aoi_pkg::PRIO_NEAR;
         hit_rsp.update_now   = zn;
      end else if (far_lt) begin
         hit_rsp.priority_res = aoi_pkg::PRIO_MID;
         hit_rsp.update_now   = zm;
      end else begin
         hit_rsp.priority_res = aoi_pkg::PRIO_FAR;
         hit_rsp.update_now   = zf;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aoi_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd.lookup ? aoi_pkg::ST_LOOK : aoi_pkg::ST_DECIDE;
            end
         end
         aoi_pkg::ST_LOOK: begin
            if (rd_vld_ff && rd_end_ff) begin
               state_in = aoi_pkg::ST_DECIDE;
            end
         end
         aoi_pkg::ST_DECIDE: begin
            if (cmd_ff.action == aoi_pkg::ACT_QUERY && found_ff) begin
               state_in = aoi_pkg::ST_QSCAN;
            end else begin
               state_in = aoi_pkg::ST_IDLE;
            end
         end
         aoi_pkg::ST_QSCAN: begin
            if (p4_end_ff) begin
               state_in = aoi_pkg::ST_FIN;
            end
         end
         aoi_pkg::ST_FIN: state_in = aoi_pkg::ST_IDLE;
         default: state_in = aoi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      issue     = 1'b0;
      mem_we    = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      clr_all   = 1'b0;
      emit      = 1'b0;
      pend_load = 1'b0;
      pend_clr  = 1'b0;
      wr_idx    = found_ff ? found_idx_ff : free_idx_ff;
      wr_entry.key = cmd_ff.entity_id;
      wr_entry.x   = cmd_ff.pos_x;
      wr_entry.y   = cmd_ff.pos_y;
      wr_entry.z   = cmd_ff.pos_z;
      emit_rsp.status       = aoi_pkg::STAT_DONE;
      emit_rsp.found_id     = '0;
      emit_rsp.priority_res = aoi_pkg::PRIO_NEAR;
      emit_rsp.update_now   = 1'b0;
      emit_rsp.last         = 1'b1;
      case (state_ff)
         aoi_pkg::ST_IDLE: pop = cmd_valid;
         aoi_pkg::ST_LOOK: issue = scan_cnt_ff < aoi_pkg::CNT_W'(aoi_pkg::MAX_ENTITIES);
         aoi_pkg::ST_DECIDE: begin
            emit = 1'b1;
            case (cmd_ff.action)
               aoi_pkg::ACT_REGISTER: begin
                  if (found_ff || free_ff) begin
                     mem_we    = 1'b1;
                     set_valid = 1'b1;
                  end else begin
                     emit_rsp.status = aoi_pkg::STAT_FULL;
                  end
               end
               aoi_pkg::ACT_MOVE: begin
                  if (found_ff) begin
                     mem_we = 1'b1;
                  end else begin
                     emit_rsp.status = aoi_pkg::STAT_UNKNOWN;
                  end
               end
               aoi_pkg::ACT_REMOVE: begin
                  if (found_ff) begin
                     clr_valid = 1'b1;
                  end else begin
                     emit_rsp.status = aoi_pkg::STAT_UNKNOWN;
                  end
               end
               aoi_pkg::ACT_QUERY: begin
                  if (found_ff) begin
                     emit = 1'b0;
                  end else begin
                     emit_rsp.status = aoi_pkg::STAT_UNKNOWN;
                  end
               end
               aoi_pkg::ACT_CLEAR: clr_all = 1'b1;
               default: ;
            endcase
         end
         aoi_pkg::ST_QSCAN: begin
            issue = scan_cnt_ff < aoi_pkg::CNT_W'(aoi_pkg::MAX_ENTITIES);
            if (hit) begin
               pend_load = 1'b1;
               if (pend_vld_ff) begin
                  emit     = 1'b1;
                  emit_rsp = pend_ff;
               end
            end
         end
         aoi_pkg::ST_FIN: begin
            emit     = 1'b1;
            pend_clr = 1'b1;
            if (pend_vld_ff) begin
               emit_rsp      = pend_ff;
               emit_rsp.last = 1'b1;
            end else begin
               emit_rsp.status = aoi_pkg::STAT_NONE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= aoi_pkg::ST_IDLE;
         valid_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rd_end_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         p2_end_ff     <= 1'b0;
         p3_vld_ff     <= 1'b0;
         p3_end_ff     <= 1'b0;
         p4_vld_ff     <= 1'b0;
         p4_end_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         scan_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
         rd_vld_ff     <= issue;
         rd_end_ff     <= issue &&
                          (scan_cnt_ff == aoi_pkg::CNT_W'(aoi_pkg::MAX_ENTITIES - 1));
         p2_vld_ff     <= rd_vld_ff && (state_ff == aoi_pkg::ST_QSCAN) &&
                          valid_ff[rd_idx_ff] && (rd_idx_ff != found_idx_ff);
         p2_end_ff     <= rd_vld_ff && rd_end_ff && (state_ff == aoi_pkg::ST_QSCAN);
         p3_vld_ff     <= p2_vld_ff;
         p3_end_ff     <= p2_end_ff;
         p4_vld_ff     <= p3_vld_ff;
         p4_end_ff     <= p3_end_ff;
         if (pop) begin
            scan_cnt_ff <= '0;
            found_ff    <= 1'b0;
            free_ff     <= 1'b0;
         end else if (state_ff == aoi_pkg::ST_DECIDE) begin
            scan_cnt_ff <= '0;
         end else if (issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (match) begin
            found_ff <= 1'b1;
         end
         if (free_hit) begin
            free_ff <= 1'b1;
         end
         if (clr_all) begin
            valid_ff <= '0;
         end else if (set_valid) begin
            valid_ff[wr_idx] <= 1'b1;
         end else if (clr_valid) begin
            valid_ff[found_idx_ff] <= 1'b0;
         end
         if (pend_load) begin
            pend_vld_ff <= 1'b1;
         end else if (pend_clr) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_ff <= mem[scan_cnt_ff[aoi_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= pop ? cmd.req : cmd_ff;
      rd_idx_ff <= scan_cnt_ff[aoi_pkg::IDX_W-1:0];
      if (match) begin
         found_idx_ff <= rd_idx_ff;
         obs_x_ff     <= rd_ff.x;
         obs_y_ff     <= rd_ff.y;
         obs_z_ff     <= rd_ff.z;
      end
      if (free_hit) begin
         free_idx_ff <= rd_idx_ff;
      end
      dx_ff     <= abs_diff(rd_ff.x, obs_x_ff);
      dy_ff     <= abs_diff(rd_ff.y, obs_y_ff);
      dz_ff     <= abs_diff(rd_ff.z, obs_z_ff);
      p2_key_ff <= rd_ff.key;
      sqx_ff    <= aoi_pkg::SQ_W'(dx_ff) * aoi_pkg::SQ_W'(dx_ff);
      sqy_ff    <= aoi_pkg::SQ_W'(dy_ff) * aoi_pkg::SQ_W'(dy_ff);
      sqz_ff    <= aoi_pkg::SQ_W'(dz_ff) * aoi_pkg::SQ_W'(dz_ff);
      p3_key_ff <= p2_key_ff;
      dist_ff   <= aoi_pkg::DIST_W'(sqx_ff) + aoi_pkg::DIST_W'(sqy_ff) +
                   aoi_pkg::DIST_W'(sqz_ff);
      p4_key_ff <= p3_key_ff;
      if (pend_load) begin
         pend_ff <= hit_rsp;
      end
      rsp_ff    <= emit_rsp;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> sv/area_of_interest_filter.sv
// ----------------------------------------------------------------------------
// area_of_interest_filter: entity table with fixed-radius neighbor query
// Configuration registers, threshold precompute, command queue and the table
// sequencer.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; up to two words
// queue ahead of the sequencer. Register, move and remove scan all 64 table
// slots once to resolve the id (one slot read per cycle from the table memory)
// and answer with one word. A query for a known id adds a second 64-slot scan
// through a four-stage distance pipeline and answers with one word per hit in
// slot order, or a single none-relevant word. Clear and undefined actions skip
// the scan and answer with one word. Every result word appears on rsp_data for
// exactly one cycle with rsp_strobe high and must be taken then. Radius and
// fraction writes reach the thresholds through the registered square, product
// and bound stages.
`timescale 1ns / 1ps

module area_of_interest_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  aoi_pkg::aoi_req_type          req_data,
   output logic                          rsp_strobe,
   output aoi_pkg::aoi_rsp_type          rsp_data,
   input  logic                          csr_we,
   input  logic [aoi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [aoi_pkg::CSR_W-1:0]     csr_wdata
);

   logic [aoi_pkg::RAD_W-1:0]  radius_ff;
   logic [aoi_pkg::FRAC_W-1:0] near_fr_ff, far_fr_ff;
   logic [aoi_pkg::IV_W-1:0]   near_iv_ff, mid_iv_ff, far_iv_ff;

   logic [aoi_pkg::RSQ_W-1:0]  r_sq_ff, r_sq2_ff;
   logic [aoi_pkg::FSQ_W-1:0]  nf2_ff, ff2_ff;
   logic [aoi_pkg::PROD_W-1:0] n_lo_ff, n_hi_ff, f_lo_ff, f_hi_ff;
   logic [aoi_pkg::BND_W-1:0]  near_b_ff, far_b_ff;
   logic [aoi_pkg::RSQ_W-1:0]  r_sq3_ff;

   aoi_pkg::aoi_thr_type       thr;
   aoi_pkg::aoi_cmd_type       cmd;
   logic                       cmd_valid;
   logic                       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= aoi_pkg::RADIUS_RST;
         near_fr_ff <= aoi_pkg::NEAR_FR_RST;
         far_fr_ff  <= aoi_pkg::FAR_FR_RST;
         near_iv_ff <= aoi_pkg::NEAR_IV_RST;
         mid_iv_ff  <= aoi_pkg::MID_IV_RST;
         far_iv_ff  <= aoi_pkg::FAR_IV_RST;
      end else if (csr_we) begin
         case (csr_index)
            aoi_pkg::CFG_RADIUS:  radius_ff  <= csr_wdata[aoi_pkg::RAD_W-1:0];
            aoi_pkg::CFG_NEAR_FR: near_fr_ff <= csr_wdata[aoi_pkg::FRAC_W-1:0];
            aoi_pkg::CFG_FAR_FR:  far_fr_ff  <= csr_wdata[aoi_pkg::FRAC_W-1:0];
            aoi_pkg::CFG_NEAR_IV: near_iv_ff <= csr_wdata[aoi_pkg::IV_W-1:0];
            aoi_pkg::CFG_MID_IV:  mid_iv_ff  <= csr_wdata[aoi_pkg::IV_W-1:0];
            aoi_pkg::CFG_FAR_IV:  far_iv_ff  <= csr_wdata[aoi_pkg::IV_W-1:0];
            default: ;
         endcase
      end
   end

   // bounds = fraction^2 * radius^2, radius^2 split in two halves
   always_ff @(posedge clock) begin
      r_sq_ff   <= aoi_pkg::RSQ_W'(radius_ff) * aoi_pkg::RSQ_W'(radius_ff);
      nf2_ff    <= aoi_pkg::FSQ_W'(near_fr_ff) * aoi_pkg::FSQ_W'(near_fr_ff);
      ff2_ff    <= aoi_pkg::FSQ_W'(far_fr_ff) * aoi_pkg::FSQ_W'(far_fr_ff);
      n_lo_ff   <= aoi_pkg::PROD_W'(nf2_ff) *
                   aoi_pkg::PROD_W'(r_sq_ff[aoi_pkg::RAD_W-1:0]);
      n_hi_ff   <= aoi_pkg::PROD_W'(nf2_ff) *
                   aoi_pkg::PROD_W'(r_sq_ff[aoi_pkg::RSQ_W-1:aoi_pkg::RAD_W]);
      f_lo_ff   <= aoi_pkg::PROD_W'(ff2_ff) *
                   aoi_pkg::PROD_W'(r_sq_ff[aoi_pkg::RAD_W-1:0]);
      f_hi_ff   <= aoi_pkg::PROD_W'(ff2_ff) *
                   aoi_pkg::PROD_W'(r_sq_ff[aoi_pkg::RSQ_W-1:aoi_pkg::RAD_W]);
      r_sq2_ff  <= r_sq_ff;
      near_b_ff <= (aoi_pkg::BND_W'(n_hi_ff) << aoi_pkg::RAD_W) + aoi_pkg::BND_W'(n_lo_ff);
      far_b_ff  <= (aoi_pkg::BND_W'(f_hi_ff) << aoi_pkg::RAD_W) + aoi_pkg::BND_W'(f_lo_ff);
      r_sq3_ff  <= r_sq2_ff;
   end

   always_comb begin
      thr.r_sq    = r_sq3_ff;
      thr.near_b  = near_b_ff;
      thr.far_b   = far_b_ff;
      thr.near_iv = near_iv_ff;
      thr.mid_iv  = mid_iv_ff;
      thr.far_iv  = far_iv_ff;
   end

   aoi_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd)
   );

   aoi_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
      .thr(thr), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_only_hits_open: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.status == aoi_pkg::STAT_HIT)
      else $error("non-final result word is not a hit");

   a_plain_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != aoi_pkg::STAT_HIT |->
      rsp_data.found_id == '0 && !rsp_data.update_now && rsp_data.last)
      else $error("status-only word carries hit fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity right after reset");
`endif

endmodule
